>>> rtl/k_group_sequence_reverser_macros.svh
// Assertion helpers shared by the RTL. Each one samples on clk and is
// switched off while rst is high.
`ifndef K_GROUP_SEQUENCE_REVERSER_MACROS_SVH
`define K_GROUP_SEQUENCE_REVERSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KGSR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KGSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/k_gsr_pkg.sv
`default_nettype none

package k_gsr_pkg;

  localparam int VALUE_W       = 32;
  localparam int GSIZE_W       = 5;
  localparam int MAX_GROUP_DEF = 16;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      list_end;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic                      run_last;
    logic                      sequence_last;
  } out_item_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  // Where the next result is taken from.
  typedef enum logic [1:0] {
    SRC_IN,
    SRC_HEAD,
    SRC_TAIL
  } src_t;

  typedef struct packed {
    logic shift_deep;
    logic shift_up;
  } chain_ctrl_t;

  typedef struct packed {
    logic load;
    src_t src;
    logic run_last;
    logic sequence_last;
  } out_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/k_gsr_cell.sv
`default_nettype none

module k_gsr_cell
  import k_gsr_pkg::*;
(
  input  wire logic                      clk,
  input  wire chain_ctrl_t               chain,
  input  wire logic signed [VALUE_W-1:0] from_shallow,
  input  wire logic signed [VALUE_W-1:0] from_deep,
  output logic signed [VALUE_W-1:0]      value
);

  always_ff @(posedge clk) begin
    if (chain.shift_deep) begin
      value <= from_shallow;
    end else if (chain.shift_up) begin
      value <= from_deep;
    end
  end

endmodule

`default_nettype wire

>>> rtl/k_gsr_ctrl.sv
`default_nettype none

`include "k_group_sequence_reverser_macros.svh"

module k_gsr_ctrl
  import k_gsr_pkg::*;
#(
  parameter int MAX_GROUP = MAX_GROUP_DEF,
  localparam int CNTW = $clog2(MAX_GROUP + 1),
  localparam int IDXW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  input  wire logic               item_list_end,
  output logic                    item_stall,
  output logic                    result_valid,
  input  wire logic               result_stall,
  input  wire logic               group_size_we,
  input  wire logic [GSIZE_W-1:0] group_size_wdata,
  output chain_ctrl_t             chain,
  output out_ctrl_t               octl,
  output logic [IDXW-1:0]         tail_idx
);

  localparam int KW = (CNTW > GSIZE_W) ? CNTW : GSIZE_W;

  state_t             state, state_next;
  logic [CNTW-1:0]    fill, fill_next;
  logic [CNTW-1:0]    remaining, remaining_next;
  logic               drain_rev, drain_rev_next;
  logic               drain_end, drain_end_next;
  logic [GSIZE_W-1:0] group_size;

  logic          out_free;
  logic          accept;
  logic [KW-1:0] gs_wide;
  logic [KW-1:0] k_eff;
  logic [KW-1:0] fill_inc;
  logic          emit_rev;
  logic          emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FILL;
      fill         <= '0;
      remaining    <= '0;
      drain_rev    <= 1'b0;
      drain_end    <= 1'b0;
      group_size   <= GSIZE_W'(1);
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      fill         <= fill_next;
      remaining    <= remaining_next;
      drain_rev    <= drain_rev_next;
      drain_end    <= drain_end_next;
      result_valid <= octl.load | (result_valid & result_stall);
      if (group_size_we) begin
        group_size <= group_size_wdata;
      end
    end
  end

  always_comb begin
    gs_wide = KW'(group_size);
    if (gs_wide == '0) begin
      k_eff = KW'(1);
    end else if (gs_wide > KW'(MAX_GROUP)) begin
      k_eff = KW'(MAX_GROUP);
    end else begin
      k_eff = gs_wide;
    end
    fill_inc = KW'(fill) + KW'(1);
    emit_rev = (fill_inc >= k_eff);
    emit     = emit_rev | item_list_end;
  end

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != ST_FILL) || !out_free;
  assign accept     = item_valid && !item_stall;
  assign tail_idx   = fill[IDXW-1:0] - IDXW'(1);

  always_comb begin
    state_next         = state;
    fill_next          = fill;
    remaining_next     = remaining;
    drain_rev_next     = drain_rev;
    drain_end_next     = drain_end;
    chain              = '0;
    octl.load          = 1'b0;
    octl.src           = SRC_IN;
    octl.run_last      = 1'b0;
    octl.sequence_last = 1'b0;

    case (state)
      ST_FILL: begin
        if (accept) begin
          if (!emit) begin
            chain.shift_deep = 1'b1;
            fill_next        = fill + CNTW'(1);
          end else begin
            // A reversed group leaves newest first, so the new value goes
            // straight out and the chain is drained from its head. An
            // in-order run leaves oldest first from the tail of the chain.
            octl.load          = 1'b1;
            octl.src           = (emit_rev || fill == '0) ? SRC_IN : SRC_TAIL;
            chain.shift_deep   = !emit_rev;
            octl.run_last      = (fill == '0);
            octl.sequence_last = item_list_end && (fill == '0);
            if (fill != '0) begin
              state_next     = ST_DRAIN;
              remaining_next = fill;
              drain_rev_next = emit_rev;
              drain_end_next = item_list_end;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          octl.load          = 1'b1;
          octl.src           = drain_rev ? SRC_HEAD : SRC_TAIL;
          chain.shift_up     = drain_rev;
          chain.shift_deep   = !drain_rev;
          remaining_next     = remaining - CNTW'(1);
          octl.run_last      = (remaining == CNTW'(1));
          octl.sequence_last = (remaining == CNTW'(1)) && drain_end;
          if (remaining == CNTW'(1)) begin
            state_next = ST_FILL;
            fill_next  = '0;
          end
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  `KGSR_ASSERT_SAME(a_drain_has_work, state == ST_DRAIN, remaining != '0, "drain with nothing left")
  `KGSR_ASSERT_SAME(a_fill_below_max, 1'b1, fill <= CNTW'(MAX_GROUP - 1), "group buffer overfilled")
  `KGSR_ASSERT_SAME(a_no_overwrite, octl.load, !(result_valid && result_stall), "stalled result overwritten")
  `KGSR_ASSERT_NEXT(a_emit_starts_drain, accept && emit && fill != '0, state == ST_DRAIN, "multi-result item did not drain")
  `KGSR_ASSERT_NEXT(a_drain_ends_empty, state == ST_DRAIN && out_free && remaining == CNTW'(1), state == ST_FILL && fill == '0, "drain did not end cleanly")

endmodule

`default_nettype wire

>>> rtl/k_group_sequence_reverser.sv
// Reorders a stream of signed 32-bit values in groups of group_size.
// Input channel: item_valid / item_stall carrying item (value, list_end).
// Output channel: result_valid / result_stall carrying result (out_value,
// run_last, sequence_last). A transfer happens on a clock edge with valid
// high and stall low.
// The user must write group_size with group_size_we only while the block
// is idle; the block itself does not enforce this. 0 and 1 pass values
// straight through, sizes above MAX_GROUP act as MAX_GROUP. Values are held
// in a chain of MAX_GROUP cells. An item that completes no run is shifted
// into the chain. An item that releases n results puts the first one in the
// output register in the cycle it is taken and shifts the other n - 1 out
// of the chain, one per cycle unless the output stalls, with item_stall
// high. Pass-through sustains one value per cycle unless result_stall is
// high. The first result is offered in the cycle after the input transfer.
// A stalled result holds in the output register and the chain pauses with it;
// item_stall stays high until the result can move on.
// Synchronous reset empties the group, drops any pending result and sets
// group_size to 1; the cell contents are not cleared.
`default_nettype none

module k_group_sequence_reverser
  import k_gsr_pkg::*;
#(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire in_item_t           item,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output out_item_t               result,
  input  wire logic               group_size_we,
  input  wire logic [GSIZE_W-1:0] group_size
);

  localparam int IDXW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  chain_ctrl_t               chain;
  out_ctrl_t                 octl;
  logic [IDXW-1:0]           tail_idx;
  logic signed [VALUE_W-1:0] cell_q [MAX_GROUP];
  logic signed [VALUE_W-1:0] next_value;

  k_gsr_ctrl #(
    .MAX_GROUP(MAX_GROUP)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_list_end   (item.list_end),
    .item_stall      (item_stall),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .group_size_we   (group_size_we),
    .group_size_wdata(group_size),
    .chain           (chain),
    .octl            (octl),
    .tail_idx        (tail_idx)
  );

  for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
    logic signed [VALUE_W-1:0] shallow_d;
    logic signed [VALUE_W-1:0] deep_d;

    if (i == 0) begin : g_first
      assign shallow_d = item.value;
    end else begin : g_inner
      assign shallow_d = cell_q[i-1];
    end

    if (i == MAX_GROUP - 1) begin : g_last
      assign deep_d = cell_q[i];
    end else begin : g_mid
      assign deep_d = cell_q[i+1];
    end

    k_gsr_cell u_cell (
      .clk         (clk),
      .chain       (chain),
      .from_shallow(shallow_d),
      .from_deep   (deep_d),
      .value       (cell_q[i])
    );
  end

  always_comb begin
    case (octl.src)
      SRC_IN:   next_value = item.value;
      SRC_HEAD: next_value = cell_q[0];
      SRC_TAIL: next_value = cell_q[tail_idx];
      default:  next_value = item.value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (octl.load) begin
      result.out_value     <= next_value;
      result.run_last      <= octl.run_last;
      result.sequence_last <= octl.sequence_last;
    end
  end

endmodule

`default_nettype wire
